### rtl/core/irne_pkg.sv
// Shared types and codes for the redirect NAT engine.
package irne_pkg;

   typedef enum logic [1:0] {
      FUNC_RULE = 2'd0,
      FUNC_OUT  = 2'd1,
      FUNC_IN   = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RULE_RD,
      ST_RULE_CMP,
      ST_NAT_RD,
      ST_NAT_CMP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic idx_clr;
      logic idx_inc;
      logic rule_rd;
      logic nat_rd;
      logic rule_wr;
      logic nat_wr;
      logic wr_new;
      logic take_to;
      logic take_orig;
      logic set_full;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     rule_end;
      logic     nat_end;
      logic     rule_hit;
      logic     nat_hit;
      logic     rule_room;
      logic     nat_room;
   } sts_type;

endpackage

### rtl/core/irne_ifs.sv
// Request and response channel interfaces of the redirect NAT engine.
interface irne_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  protocol;
   logic [31:0] source_address;
   logic [31:0] destination_address;
   logic [15:0] source_port;
   logic [15:0] destination_port;
   logic        ports_present;
   logic [31:0] rule_old_address;
   logic [31:0] rule_new_address;

   modport source (output valid, func, protocol, source_address, destination_address,
                   source_port, destination_port, ports_present, rule_old_address,
                   rule_new_address, input ready);
   modport sink (input valid, func, protocol, source_address, destination_address,
                 source_port, destination_port, ports_present, rule_old_address,
                 rule_new_address, output ready);
endinterface

interface irne_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_source_address;
   logic [31:0] out_destination_address;
   logic        rewritten;
   logic        table_full;

   modport source (output valid, out_source_address, out_destination_address,
                   rewritten, table_full, input ready);
   modport sink (input valid, out_source_address, out_destination_address,
                 rewritten, table_full, output ready);
endinterface

### rtl/core/irne_dpath.sv
// Datapath: item registers, rule and connection tables, scan index, result registers.
module irne_dpath #(
   parameter int RULE_ENTRIES = 16,
   parameter int NAT_ENTRIES  = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  irne_pkg::cmd_type cmd,
   output irne_pkg::sts_type sts,
   input  logic [1:0]       req_func,
   input  logic [7:0]       req_protocol,
   input  logic [31:0]      req_source_address,
   input  logic [31:0]      req_destination_address,
   input  logic [15:0]      req_source_port,
   input  logic [15:0]      req_destination_port,
   input  logic             req_ports_present,
   input  logic [31:0]      req_rule_old_address,
   input  logic [31:0]      req_rule_new_address,
   output logic [31:0]      rsp_out_source_address,
   output logic [31:0]      rsp_out_destination_address,
   output logic             rsp_rewritten,
   output logic             rsp_table_full
);
   import irne_pkg::*;

   localparam int RCW = $clog2(RULE_ENTRIES + 1);
   localparam int NCW = $clog2(NAT_ENTRIES + 1);
   localparam int RAW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
   localparam int NAW = (NAT_ENTRIES > 1) ? $clog2(NAT_ENTRIES) : 1;
   localparam int IW  = (RCW > NCW) ? RCW : NCW;

   func_type    func_ff;
   logic [7:0]  proto_ff;
   logic [31:0] src_ff, dst_ff, old_ff, new_ff;
   logic [15:0] sport_ff, dport_ff;

   logic [IW-1:0]  idx_ff, idx_in;
   logic [RCW-1:0] rcount_ff, rcount_in;
   logic [NCW-1:0] ncount_ff, ncount_in;

   logic [63:0]  rule_mem [RULE_ENTRIES];
   logic [135:0] nat_mem [NAT_ENTRIES];
   logic [63:0]  rule_rd_ff;
   logic [135:0] nat_rd_ff;

   logic [31:0] osrc_ff, odst_ff;
   logic        rew_ff, full_ff;

   logic [31:0]  rule_key;
   logic [103:0] nat_key;
   logic [RAW-1:0] rule_wa;
   logic [NAW-1:0] nat_wa;

   // hold the item; ports count as zero without a transport header
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= func_type'(req_func);
         proto_ff <= req_protocol;
         src_ff   <= req_source_address;
         dst_ff   <= req_destination_address;
         sport_ff <= req_ports_present ? req_source_port : 16'd0;
         dport_ff <= req_ports_present ? req_destination_port : 16'd0;
         old_ff   <= req_rule_old_address;
         new_ff   <= req_rule_new_address;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IW'(1);
      end
      rcount_in = rcount_ff;
      if (cmd.rule_wr && cmd.wr_new) begin
         rcount_in = rcount_ff + RCW'(1);
      end
      ncount_in = ncount_ff;
      if (cmd.nat_wr && cmd.wr_new) begin
         ncount_in = ncount_ff + NCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rcount_ff <= '0;
         ncount_ff <= '0;
      end else begin
         idx_ff    <= idx_in;
         rcount_ff <= rcount_in;
         ncount_ff <= ncount_in;
      end
   end

   // new entries go to the lowest free slot, which is the fill count
   assign rule_wa = cmd.wr_new ? rcount_ff[RAW-1:0] : idx_ff[RAW-1:0];
   assign nat_wa  = cmd.wr_new ? ncount_ff[NAW-1:0] : idx_ff[NAW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rule_wr) begin
         rule_mem[rule_wa] <= {old_ff, new_ff};
      end
      if (cmd.rule_rd) begin
         rule_rd_ff <= rule_mem[idx_ff[RAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nat_wr) begin
         nat_mem[nat_wa] <= {src_ff, odst_ff, sport_ff, dport_ff, proto_ff, dst_ff};
      end
      if (cmd.nat_rd) begin
         nat_rd_ff <= nat_mem[idx_ff[NAW-1:0]];
      end
   end

   always_comb begin
      rule_key = (func_ff == FUNC_RULE) ? old_ff : dst_ff;
      if (func_ff == FUNC_IN) begin
         nat_key = {dst_ff, src_ff, dport_ff, sport_ff, proto_ff};
      end else begin
         nat_key = {src_ff, odst_ff, sport_ff, dport_ff, proto_ff};
      end
   end

   always_comb begin
      sts.func      = func_ff;
      sts.rule_end  = (idx_ff == IW'(rcount_ff));
      sts.nat_end   = (idx_ff == IW'(ncount_ff));
      sts.rule_hit  = (rule_rd_ff[63:32] == rule_key);
      sts.nat_hit   = (nat_rd_ff[135:32] == nat_key);
      sts.rule_room = (rcount_ff != RCW'(RULE_ENTRIES));
      sts.nat_room  = (ncount_ff != NCW'(NAT_ENTRIES));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         osrc_ff <= (func_type'(req_func) == FUNC_RULE) ? 32'd0 : req_source_address;
         odst_ff <= (func_type'(req_func) == FUNC_RULE) ? 32'd0 : req_destination_address;
         rew_ff  <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         if (cmd.take_to) begin
            odst_ff <= rule_rd_ff[31:0];
            rew_ff  <= 1'b1;
         end
         if (cmd.take_orig) begin
            osrc_ff <= nat_rd_ff[31:0];
            rew_ff  <= 1'b1;
         end
         if (cmd.set_full) begin
            full_ff <= 1'b1;
         end
      end
   end

   assign rsp_out_source_address      = osrc_ff;
   assign rsp_out_destination_address = odst_ff;
   assign rsp_rewritten               = rew_ff;
   assign rsp_table_full              = full_ff;

endmodule

### rtl/core/irne_ctrl.sv
// Controller: sequences table scans, writes and the response handshake.
module irne_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  irne_pkg::sts_type sts,
   output irne_pkg::cmd_type cmd
);
   import irne_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (sts.func)
               FUNC_RULE, FUNC_OUT: state_in = ST_RULE_RD;
               FUNC_IN:             state_in = ST_NAT_RD;
               FUNC_NONE:           state_in = ST_RESP;
            endcase
         end
         ST_RULE_RD: begin
            state_in = sts.rule_end ? ST_RESP : ST_RULE_CMP;
         end
         ST_RULE_CMP: begin
            if (!sts.rule_hit) begin
               state_in = ST_RULE_RD;
            end else if (sts.func == FUNC_RULE) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_NAT_RD;
            end
         end
         ST_NAT_RD: begin
            state_in = sts.nat_end ? ST_RESP : ST_NAT_CMP;
         end
         ST_NAT_CMP: begin
            state_in = sts.nat_hit ? ST_RESP : ST_NAT_RD;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load    = req_valid;
            cmd.idx_clr = req_valid;
         end
         ST_DISPATCH: begin
         end
         ST_RULE_RD: begin
            if (!sts.rule_end) begin
               cmd.rule_rd = 1'b1;
            end else if (sts.func == FUNC_RULE) begin
               // new old-address: append if there is room
               cmd.rule_wr  = sts.rule_room;
               cmd.wr_new   = sts.rule_room;
               cmd.set_full = !sts.rule_room;
            end
         end
         ST_RULE_CMP: begin
            if (!sts.rule_hit) begin
               cmd.idx_inc = 1'b1;
            end else if (sts.func == FUNC_RULE) begin
               cmd.rule_wr = 1'b1;
            end else begin
               cmd.take_to = 1'b1;
               cmd.idx_clr = 1'b1;
            end
         end
         ST_NAT_RD: begin
            if (!sts.nat_end) begin
               cmd.nat_rd = 1'b1;
            end else if (sts.func == FUNC_OUT) begin
               cmd.nat_wr   = sts.nat_room;
               cmd.wr_new   = sts.nat_room;
               cmd.set_full = !sts.nat_room;
            end
         end
         ST_NAT_CMP: begin
            if (!sts.nat_hit) begin
               cmd.idx_inc = 1'b1;
            end else if (sts.func == FUNC_OUT) begin
               cmd.nat_wr = 1'b1;
            end else begin
               cmd.take_orig = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/core/ip_redirect_nat_engine.sv
// Top level of the destination-redirect NAT engine.
//
// Usage: header and rule items enter on req_chan (valid/ready); one result
// item per input leaves on rsp_chan. func selects the operation: add rule,
// outbound header, inbound header; the fourth code passes the header through.
// Rules and connection entries live in on-chip memories filled from slot 0
// upward; a fill count marks the occupied slots, so no clearing pass is run.
//
// Scan: each lookup scans the occupied slots one at a time, in a read state
// (address) and then a compare state (against registered read data) for each
// slot. A scan stops at a hit or at the end of the table.
// Throughput: one item at a time; the next item is taken after the result
// leaves. The scan over each table's single memory read port sets the pace.
//
// Reset (synchronous, active high) empties both tables and returns to idle.
// A stalled receiver holds the result registers; req_chan.ready stays low.
module ip_redirect_nat_engine #(
   parameter int RULE_ENTRIES = 16,
   parameter int NAT_ENTRIES  = 256
) (
   input logic       clock,
   input logic       reset,
   irne_req_if.sink  req_chan,
   irne_rsp_if.source rsp_chan
);
   import irne_pkg::*;

   cmd_type cmd;
   sts_type sts;

   irne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   irne_dpath #(
      .RULE_ENTRIES (RULE_ENTRIES),
      .NAT_ENTRIES  (NAT_ENTRIES)
   ) u_dpath (
      .clock                       (clock),
      .reset                       (reset),
      .cmd                         (cmd),
      .sts                         (sts),
      .req_func                    (req_chan.func),
      .req_protocol                (req_chan.protocol),
      .req_source_address          (req_chan.source_address),
      .req_destination_address     (req_chan.destination_address),
      .req_source_port             (req_chan.source_port),
      .req_destination_port        (req_chan.destination_port),
      .req_ports_present           (req_chan.ports_present),
      .req_rule_old_address        (req_chan.rule_old_address),
      .req_rule_new_address        (req_chan.rule_new_address),
      .rsp_out_source_address      (rsp_chan.out_source_address),
      .rsp_out_destination_address (rsp_chan.out_destination_address),
      .rsp_rewritten               (rsp_chan.rewritten),
      .rsp_table_full              (rsp_chan.table_full)
   );

endmodule

### rtl/core/irne_chk.sv
// Port-level checker for the redirect NAT engine, with its bind.
module irne_chk (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   logic pend_ff;

   // track an accepted item whose result has not left
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         pend_ff <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
         pend_ff <= 1'b0;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_needs_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff)
      else $error("result without accepted item");

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_ready)
      else $error("item taken while one is in flight");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");

endmodule

bind ip_redirect_nat_engine irne_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);
